/* rtl/prime_progression_run_length_macros.svh */
// Assertion macros used by the checker of the prime run length block.
`ifndef PRIME_PROGRESSION_RUN_LENGTH_MACROS_SVH
`define PRIME_PROGRESSION_RUN_LENGTH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define PPR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppr assertion failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define PPR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppr assertion failed");

`endif

/* rtl/ppr_pkg.sv */
// Package for the prime run length block: sequencer states, status struct, constants.
package ppr_pkg;

  // Width of the result field; a full run of 64 saturates to all ones.
  localparam int unsigned RUN_W = 6;

  // Smallest trial divisor.
  localparam int unsigned FIRST_DIVISOR = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_TEST,
    ST_DIV,
    ST_DONE
  } ppr_state_e;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } ppr_rem_sts_t;

endpackage

/* rtl/ppr_rem_unit.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ppr_rem_unit #(
  parameter int unsigned TERM_W = 22,
  parameter int unsigned DIV_W  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TERM_W-1:0]     dividend_i,
  input  logic [DIV_W-1:0]      divisor_i,
  output ppr_pkg::ppr_rem_sts_t sts_o
);
  import ppr_pkg::*;

  localparam int unsigned CNT_W = $clog2(TERM_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [TERM_W-1:0] num_q, num_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              busy;

  assign busy  = (cnt_q != '0);
  assign trial = {rem_q, num_q[TERM_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d = CNT_W'(TERM_W);
      num_d = dividend_i;
      rem_d = '0;
    end else if (busy) begin
      // shift in next bit, subtract when it fits
      num_d = {num_q[TERM_W-2:0], 1'b0};
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

/* rtl/prime_progression_run_length.sv */
// Top level of the prime run length block: sequencer, term and divisor registers, result register.
// Counts how many leading terms first_term + i*step (i = 0 .. MAX_TERMS-1) are prime, stopping
// at the first term that is not; 0 and 1 are not prime and a run of 64 reads as 63. One item
// is worked at a time and in_stall_o stays high until its result is loaded into the output
// register. Each term is tested by trial division with d = 2 and then every odd d while
// d*d <= term, all through one bit-serial remainder unit on TERM_W-bit terms (TERM_W =
// INPUT_BITS + clog2(MAX_TERMS), 22 at the defaults). A finished item waits while the
// previous result sits stalled at the output.
module prime_progression_run_length #(
  parameter int unsigned MAX_TERMS  = 50,
  parameter int unsigned INPUT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [INPUT_BITS-1:0]     first_term_i,
  input  logic [INPUT_BITS-1:0]     step_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ppr_pkg::RUN_W-1:0] prime_run_o
);
  import ppr_pkg::*;

  localparam int unsigned TERM_W = INPUT_BITS + $clog2(MAX_TERMS);
  localparam int unsigned DIV_W  = (TERM_W + 1) / 2 + 1;
  localparam int unsigned SQ_W   = 2 * DIV_W;
  localparam int unsigned CNT_W  = RUN_W + 1;

  localparam logic [DIV_W-1:0] DivFirst  = DIV_W'(FIRST_DIVISOR);
  localparam logic [DIV_W-1:0] DivSecond = DIV_W'(FIRST_DIVISOR + 1);
  localparam logic [SQ_W-1:0]  SqFirst   = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
  localparam logic [SQ_W-1:0]  SqSecond  = SQ_W'((FIRST_DIVISOR + 1) * (FIRST_DIVISOR + 1));
  localparam logic [CNT_W-1:0] LastRun   = CNT_W'(MAX_TERMS - 1);

  ppr_state_e state_q, state_d;

  logic [TERM_W-1:0]     term_q;
  logic [INPUT_BITS-1:0] step_q;
  logic [DIV_W-1:0]      div_q;
  logic [SQ_W-1:0]       sq_q;
  logic [CNT_W-1:0]      run_q;
  logic                  out_valid_q;
  logic [RUN_W-1:0]      prime_run_q;

  logic term_lt2, sq_gt, last_term, out_free;
  logic load_in, init_div, term_prime, advance, start_div, next_div, emit;

  ppr_rem_sts_t rem_sts;

  assign term_lt2  = (term_q < TERM_W'(FIRST_DIVISOR));
  assign sq_gt     = (sq_q > SQ_W'(term_q));
  assign last_term = (run_q == LastRun);
  assign out_free  = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_TERM;
      ST_TERM: state_d = term_lt2 ? ST_DONE : ST_TEST;
      ST_TEST: begin
        if (sq_gt) state_d = last_term ? ST_DONE : ST_TERM;
        else       state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sts.done) state_d = rem_sts.rem_zero ? ST_DONE : ST_TEST;
      end
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    load_in    = 1'b0;
    init_div   = 1'b0;
    term_prime = 1'b0;
    advance    = 1'b0;
    start_div  = 1'b0;
    next_div   = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: load_in = in_valid_i;
      ST_TERM: init_div = 1'b1;
      ST_TEST: begin
        term_prime = sq_gt;
        advance    = sq_gt && !last_term;
        start_div  = !sq_gt;
      end
      ST_DIV:  next_div = rem_sts.done && !rem_sts.rem_zero;
      ST_DONE: emit = out_free;
      default: ;
    endcase
  end

  ppr_rem_unit #(
    .TERM_W(TERM_W),
    .DIV_W (DIV_W)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_div),
    .dividend_i(term_q),
    .divisor_i (div_q),
    .sts_o     (rem_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_in)         run_q <= '0;
      else if (term_prime) run_q <= run_q + 1'b1;
      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      term_q <= TERM_W'(first_term_i);
      step_q <= step_i;
    end else if (advance) begin
      term_q <= term_q + TERM_W'(step_q);
    end
    if (init_div) begin
      div_q <= DivFirst;
      sq_q  <= SqFirst;
    end else if (next_div) begin
      // after 2 try odd divisors only; (d+2)^2 = d^2 + 4d + 4
      if (div_q == DivFirst) begin
        div_q <= DivSecond;
        sq_q  <= SqSecond;
      end else begin
        div_q <= div_q + DIV_W'(2);
        sq_q  <= sq_q + SQ_W'({div_q, 2'b00}) + SQ_W'(4);
      end
    end
    // saturate a full run of 64
    if (emit) prime_run_q <= run_q[RUN_W] ? '1 : run_q[RUN_W-1:0];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign prime_run_o = prime_run_q;

endmodule

/* rtl/ppr_checker.sv */
// Port-level checker for the prime run length block and its bind.
`include "prime_progression_run_length_macros.svh"

module ppr_checker #(
  parameter int unsigned MAX_TERMS  = 50,
  parameter int unsigned INPUT_BITS = 16
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [INPUT_BITS-1:0]     first_term_i,
  input logic [INPUT_BITS-1:0]     step_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [ppr_pkg::RUN_W-1:0] prime_run_o
);
  import ppr_pkg::*;

  logic in_acc, out_acc, out_hold;
  logic run_ok;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign out_hold = out_valid_o && out_stall_i;
  assign run_ok   = ({1'b0, prime_run_o} <= (RUN_W + 1)'(MAX_TERMS));

  // a stalled result holds
  `PPR_ASSERT_NXT(a_out_hold, out_hold, out_valid_o && $stable(prime_run_o))
  // one item at a time: busy right after an accept
  `PPR_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall_o)
  // a run never exceeds the number of terms
  `PPR_ASSERT_IMP(a_run_range, out_valid_o, run_ok)
  // a new result never shows up in the cycle after one was taken while idle
  `PPR_ASSERT_NXT(a_no_spurious, out_acc && !in_stall_o && !in_valid_i, !out_valid_o)

endmodule

bind prime_progression_run_length ppr_checker #(
  .MAX_TERMS (MAX_TERMS),
  .INPUT_BITS(INPUT_BITS)
) u_ppr_checker (.*);

/* test/tb_prime_progression_run_length.sv */
// Self-checking testbench for the prime run length block: directed and random items, scoreboarded.
module tb_prime_progression_run_length;
  timeunit 1ns;
  timeprecision 1ps;

  import ppr_pkg::*;

  localparam int unsigned MAX_TERMS  = 50;
  localparam int unsigned INPUT_BITS = 16;
  localparam int unsigned RUN_MAX    = (1 << RUN_W) - 1;
  // The watchdog limit must cover an item whose terms are all near 2^22 and prime.
  localparam int unsigned QUIET_LIMIT   = 6_000_000;
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned ITEMS_PER_PHASE = 75;

  class prime_run_board;
    logic [RUN_W-1:0] expected_runs[$];
    int unsigned      mismatches = 0;
    int unsigned      checked = 0;
    int unsigned      longest = 0;

    function bit is_prime(longint unsigned n);
      if (n < 2) return 1'b0;
      for (longint unsigned d = FIRST_DIVISOR; d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(logic [INPUT_BITS-1:0] first, logic [INPUT_BITS-1:0] step);
      longint unsigned term;
      int unsigned     run;
      run = 0;
      for (int unsigned i = 0; i < MAX_TERMS; i++) begin
        term = 64'(first) + 64'(step) * 64'(i);
        if (!is_prime(term)) break;
        run++;
      end
      if (run > longest) longest = run;
      if (run > RUN_MAX) run = RUN_MAX;
      expected_runs.push_back(RUN_W'(run));
    endfunction

    function void check_result(logic [RUN_W-1:0] actual);
      logic [RUN_W-1:0] exp_run;
      if (expected_runs.size() == 0) begin
        $error("prime_run: result with no item pending, expected none, actual %0d", actual);
        mismatches++;
        return;
      end
      exp_run = expected_runs.pop_front();
      checked++;
      if (actual !== exp_run) begin
        $error("prime_run mismatch: expected %0d, actual %0d", exp_run, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [INPUT_BITS-1:0] first_term_i = '0;
  logic [INPUT_BITS-1:0] step_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [RUN_W-1:0]      prime_run_o;

  prime_run_board board = new;
  int unsigned    send_idle = 0;
  int unsigned    recv_stall = 0;
  int unsigned    items_sent = 0;
  int unsigned    quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  prime_progression_run_length #(
    .MAX_TERMS (MAX_TERMS),
    .INPUT_BITS(INPUT_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .first_term_i(first_term_i),
    .step_i      (step_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .prime_run_o (prime_run_o)
  );

  // Check accepted results and draw the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(prime_run_o);
    out_stall_i <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_prime_progression_run_length: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [INPUT_BITS-1:0] first,
                           input logic [INPUT_BITS-1:0] step);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    first_term_i <= first;
    step_i       <= step;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(first, step);
    items_sent++;
  endtask

  initial begin
    int unsigned           send_pct[4] = '{0, 61, 0, 15};
    int unsigned           recv_pct[4] = '{0, 0, 61, 15};
    logic [INPUT_BITS-1:0] first;
    logic [INPUT_BITS-1:0] step;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Values below two, zero step, field extremes, known long progressions.
    send_item(16'd0, 16'd0);
    send_item(16'd1, 16'd0);
    send_item(16'd1, 16'd1);
    send_item(16'd0, 16'hFFFF);
    send_item(16'hFFFF, 16'd0);
    send_item(16'd4, 16'd0);
    send_item(16'd2, 16'd0);
    send_item(16'd2, 16'd1);
    send_item(16'd3, 16'd2);
    send_item(16'd5, 16'd6);
    send_item(16'd7, 16'd150);
    send_item(16'd199, 16'd210);
    send_item(16'd2, 16'hFFFF);
    send_item(16'd65521, 16'd0);
    send_item(16'd65521, 16'hFFFF);
    send_item(16'hFFFF, 16'hFFFF);
    send_item(16'h5555, 16'hAAAA);
    send_item(16'hAAAA, 16'h5555);
    send_item(16'h8000, 16'd1);
    send_item(16'd3, 16'hFFFE);

    for (int p = 0; p < 4; p++) begin
      send_idle  = send_pct[p];
      recv_stall = recv_pct[p];
      repeat (ITEMS_PER_PHASE) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // Start on a prime and use an even step so the run gets past the first term.
            first = INPUT_BITS'($urandom_range(2, 4095));
            while (!board.is_prime(64'(first))) first++;
            case ($urandom_range(3))
              0:       step = INPUT_BITS'(2 * $urandom_range(1, 60));
              1:       step = INPUT_BITS'(6 * $urandom_range(1, 40));
              2:       step = INPUT_BITS'(30 * $urandom_range(1, 20));
              default: step = INPUT_BITS'(210 * $urandom_range(1, 8));
            endcase
          end
          4, 5: begin
            first = INPUT_BITS'($urandom_range(255));
            step  = INPUT_BITS'($urandom_range(255));
          end
          6, 7: begin
            first = INPUT_BITS'($urandom);
            step  = INPUT_BITS'($urandom);
          end
          8: begin
            first = INPUT_BITS'($urandom_range(4095));
            step  = '0;
          end
          default: begin
            first = INPUT_BITS'($urandom_range(3));
            step  = INPUT_BITS'($urandom);
          end
        endcase
        send_item(first, step);
      end
    end
    in_valid_i <= 1'b0;

    while (board.expected_runs.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d items through four idle/stall mixes; %0d results checked, longest run %0d.",
             items_sent, board.checked, board.longest);
    if (board.mismatches == 0 && board.expected_runs.size() == 0) begin
      $display("tb_prime_progression_run_length: PASS");
    end else begin
      $display("tb_prime_progression_run_length: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ppr_pkg.sv
rtl/ppr_rem_unit.sv
rtl/prime_progression_run_length.sv
rtl/ppr_checker.sv
test/tb_prime_progression_run_length.sv
